// File: hw/rtl/jkv_pkg.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor package
// Shared beat types, status codes, register indexes and character constants.
// ----------------------------------------------------------------------------
package jkv_pkg;

   // Input beat: one document byte and its end marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_document;
   } req_payload_type;

   // Result beat: either a decoded character or the final status.
   typedef struct packed {
      logic              is_final;
      logic [7:0]        value_char;
      logic [2:0]        status;
      logic signed [31:0] int_value;
      logic [11:0]       string_length;
   } rsp_payload_type;

   // Up to two result beats produced by one input beat.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } push_type;

   // Configuration values other than the key bytes.
   typedef struct packed {
      logic [5:0]  key_length;
      logic        value_kind;
      logic [11:0] max_value_chars;
   } cfg_type;

   // Status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_FORMAT    = 3'd2;
   localparam logic [2:0] STATUS_BUFFER    = 3'd3;
   localparam logic [2:0] STATUS_EMPTY_KEY = 3'd4;

   // Register indexes.
   localparam logic [2:0] CSR_KEY_BYTES_0_7   = 3'd0;
   localparam logic [2:0] CSR_KEY_LENGTH      = 3'd4;
   localparam logic [2:0] CSR_VALUE_KIND      = 3'd5;
   localparam logic [2:0] CSR_MAX_VALUE_CHARS = 3'd6;

   // Value kinds.
   localparam logic KIND_STRING = 1'b0;

   // Reset value of the character limit.
   localparam logic [11:0] MAX_CHARS_RESET = 12'd63;

   // Characters.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;

   // Depth of the result queue; it must hold at least two beats.
   localparam int RSP_DEPTH = 4;

   // JSON whitespace test.
   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

endpackage

// File: hw/rtl/json_key_value_extractor_core.sv
// The beats of an accepted byte enter the registered result queue. Throughput: one byte
// per cycle while req_ready is high; the parser state updates once per byte in one pass.
// A byte that ends the document may yield two beats; the four-entry result queue drains
// one beat per cycle while rsp_ready is high, and req_ready drops while fewer than two
// entries are free. Reset: clears the parser state and result queue and resets registers.
// ----------------------------------------------------------------------------
// JSON key/value extractor
// Finds a configured key in a JSON byte stream and returns its string value as
// character beats then a final status beat, or its integer value in the status beat.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core import jkv_pkg::*; #(
   parameter int KEY_MAX_BYTES   = 32,
   parameter int VALUE_MAX_CHARS = 4095
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [2:0]      csr_index,
   input  logic [63:0]     csr_wdata
);

   logic [7:0] key_bytes [KEY_MAX_BYTES];
   cfg_type    cfg;
   push_type   push;
   logic       room;
   logic       take;

   // An input beat is taken only out of reset and when the queue can absorb two results.
   assign req_ready = room && !reset;
   assign take      = req_valid && req_ready;

   jkv_csr #(
      .KEY_MAX_BYTES(KEY_MAX_BYTES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key_bytes (key_bytes),
      .cfg       (cfg)
   );

   jkv_parse #(
      .KEY_MAX_BYTES  (KEY_MAX_BYTES),
      .VALUE_MAX_CHARS(VALUE_MAX_CHARS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_payload(req_payload),
      .key_bytes  (key_bytes),
      .cfg        (cfg),
      .push       (push)
   );

   jkv_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// File: hw/rtl/jkv_csr.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor configuration registers
// Holds the key bytes, key length, value kind and character limit.
// ----------------------------------------------------------------------------
module jkv_csr import jkv_pkg::*; #(
   parameter int KEY_MAX_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output logic [7:0]  key_bytes [KEY_MAX_BYTES],
   output cfg_type     cfg
);

   logic [7:0] key_ff [KEY_MAX_BYTES];
   cfg_type    cfg_ff;

   // Each key byte lives in one 64-bit register at a fixed byte lane.
   for (genvar g = 0; g < KEY_MAX_BYTES; g++) begin : g_key
      localparam int GRP  = g / 8;
      localparam int LANE = g % 8;
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[g] <= 8'd0;
         end else if (csr_wr_en && (csr_index == CSR_KEY_BYTES_0_7 + 3'(GRP))) begin
            key_ff[g] <= csr_wdata[LANE*8 +: 8];
         end
      end
      assign key_bytes[g] = key_ff[g];
   end

   // Scalar configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_length      <= 6'd0;
         cfg_ff.value_kind      <= KIND_STRING;
         cfg_ff.max_value_chars <= MAX_CHARS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_LENGTH:      cfg_ff.key_length      <= csr_wdata[5:0];
            CSR_VALUE_KIND:      cfg_ff.value_kind      <= csr_wdata[0];
            CSR_MAX_VALUE_CHARS: cfg_ff.max_value_chars <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/jkv_parse.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor parser
// Per-byte state machine: key match, colon search, value decode, final status.
// ----------------------------------------------------------------------------
module jkv_parse import jkv_pkg::*; #(
   parameter int KEY_MAX_BYTES   = 32,
   parameter int VALUE_MAX_CHARS = 4095
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_payload_type req_payload,
   input  logic [7:0]      key_bytes [KEY_MAX_BYTES],
   input  cfg_type         cfg,
   output push_type        push
);

   localparam int KPW     = $clog2(KEY_MAX_BYTES + 1);
   localparam int LIM_MAX = (VALUE_MAX_CHARS < 4095) ? VALUE_MAX_CHARS : 4095;
   localparam int CNT_W   = (LIM_MAX > 1) ? $clog2(LIM_MAX + 1) : 1;

   typedef enum logic [2:0] {
      PH_SCAN,
      PH_KEY,
      PH_COLON,
      PH_PRESPACE,
      PH_STRVAL,
      PH_INTVAL,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [KPW-1:0]     key_pos_ff, key_pos_in;
   logic               key_match_ff, key_match_in;
   logic               esc_ff, esc_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [31:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               digit_ff, digit_in;

   logic [7:0]      b;
   logic            last;
   logic [5:0]      klen;
   logic [11:0]     limit;
   logic            key_hit;
   logic            do_int;
   logic [7:0]      ch;
   logic            emit;
   logic            res_a_vld, res_b_vld;
   rsp_payload_type res_a, res_b;

   assign b    = req_payload.data_byte;
   assign last = req_payload.end_of_document;

   // Effective key length and character limit.
   assign klen  = (cfg.key_length > 6'(KEY_MAX_BYTES)) ? 6'(KEY_MAX_BYTES) : cfg.key_length;
   assign limit = (cfg.max_value_chars > 12'(LIM_MAX)) ? 12'(LIM_MAX) : cfg.max_value_chars;

   // Compare the byte with the key character at the current position.
   always_comb begin
      key_hit = 1'b0;
      for (int i = 0; i < KEY_MAX_BYTES; i++) begin
         if ((key_pos_ff == KPW'(i)) && (key_bytes[i] == b)) begin
            key_hit = 1'b1;
         end
      end
   end

   // Next state and result beats for the byte on the input.
   always_comb begin
      phase_in     = phase_ff;
      key_pos_in   = key_pos_ff;
      key_match_in = key_match_ff;
      esc_in       = esc_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      digit_in     = digit_ff;
      do_int       = 1'b0;
      ch           = b;
      emit         = 1'b0;
      res_a_vld    = 1'b0;
      res_b_vld    = 1'b0;
      res_a        = '0;
      res_b        = '0;
      res_a.is_final = 1'b1;
      res_b.is_final = 1'b1;

      if ((phase_ff != PH_DONE) && (klen == 6'd0)) begin
         // Empty key: bytes are ignored until the end of the document.
         if (last) begin
            res_b_vld    = 1'b1;
            res_b.status = STATUS_EMPTY_KEY;
         end
      end else begin
         case (phase_ff)
            PH_SCAN: begin
               if (b == CH_QUOTE) begin
                  phase_in     = PH_KEY;
                  key_pos_in   = '0;
                  key_match_in = 1'b1;
                  esc_in       = 1'b0;
               end
            end
            PH_KEY: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (b == CH_BACKSLASH) begin
                  esc_in       = 1'b1;
                  key_match_in = 1'b0;
               end else if (b == CH_QUOTE) begin
                  phase_in = (key_match_ff && (6'(key_pos_ff) == klen)) ? PH_COLON : PH_SCAN;
               end else if (key_match_ff) begin
                  if ((6'(key_pos_ff) < klen) && key_hit) begin
                     key_pos_in = key_pos_ff + 1'b1;
                  end else begin
                     key_match_in = 1'b0;
                  end
               end
            end
            PH_COLON: begin
               if (b == CH_COLON) begin
                  phase_in = PH_PRESPACE;
               end else if (b == CH_QUOTE) begin
                  phase_in     = PH_KEY;
                  key_pos_in   = '0;
                  key_match_in = 1'b1;
                  esc_in       = 1'b0;
               end else if (!is_space(b)) begin
                  phase_in = PH_SCAN;
               end
            end
            PH_PRESPACE: begin
               if (!is_space(b)) begin
                  if (cfg.value_kind == KIND_STRING) begin
                     if (b == CH_QUOTE) begin
                        phase_in = PH_STRVAL;
                        count_in = '0;
                        esc_in   = 1'b0;
                     end else begin
                        res_a_vld    = 1'b1;
                        res_a.status = STATUS_FORMAT;
                        phase_in     = PH_DONE;
                     end
                  end else if (b == CH_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_INTVAL;
                  end else begin
                     // The byte is the first of the number.
                     phase_in = PH_INTVAL;
                     do_int   = 1'b1;
                  end
               end
            end
            PH_INTVAL: begin
               do_int = 1'b1;
            end
            PH_STRVAL: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  emit   = 1'b1;
                  case (b)
                     CH_QUOTE, CH_BACKSLASH, CH_SLASH: ch = b;
                     CH_LOWER_B: ch = CH_BS;
                     CH_LOWER_F: ch = CH_FF;
                     CH_LOWER_N: ch = CH_LF;
                     CH_LOWER_R: ch = CH_CR;
                     CH_LOWER_T: ch = CH_TAB;
                     default: begin
                        emit         = 1'b0;
                        res_a_vld    = 1'b1;
                        res_a.status = STATUS_FORMAT;
                        phase_in     = PH_DONE;
                     end
                  endcase
               end else if (b == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (b == CH_QUOTE) begin
                  res_a_vld           = 1'b1;
                  res_a.status        = STATUS_OK;
                  res_a.string_length = 12'(count_ff);
                  phase_in            = PH_DONE;
               end else begin
                  emit = 1'b1;
               end
               // Emit the decoded character unless the buffer is full.
               if (emit) begin
                  res_a_vld = 1'b1;
                  if (12'(count_ff) >= limit) begin
                     res_a.status = STATUS_BUFFER;
                     phase_in     = PH_DONE;
                  end else begin
                     res_a.is_final   = 1'b0;
                     res_a.value_char = ch;
                     count_in         = count_ff + 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         // Integer digit step; the accumulator already carries the sign.
         if (do_int) begin
            if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
               if (neg_ff) begin
                  acc_in = (acc_ff <<< 3) + (acc_ff <<< 1) - $signed(32'(b[3:0]));
               end else begin
                  acc_in = (acc_ff <<< 3) + (acc_ff <<< 1) + $signed(32'(b[3:0]));
               end
               digit_in = 1'b1;
            end else begin
               res_a_vld = 1'b1;
               if (digit_ff) begin
                  res_a.status    = STATUS_OK;
                  res_a.int_value = acc_ff;
               end else begin
                  res_a.status = STATUS_FORMAT;
               end
               phase_in = PH_DONE;
            end
         end

         // Final status at the end of the document if none was given.
         if (last) begin
            if ((phase_in == PH_SCAN) || (phase_in == PH_COLON)) begin
               res_b_vld    = 1'b1;
               res_b.status = STATUS_NOT_FOUND;
            end else if ((phase_in == PH_INTVAL) && digit_in) begin
               res_b_vld       = 1'b1;
               res_b.status    = STATUS_OK;
               res_b.int_value = acc_in;
            end else if (phase_in != PH_DONE) begin
               res_b_vld    = 1'b1;
               res_b.status = STATUS_FORMAT;
            end
         end
      end

      // End of document returns the per-document state to its reset values.
      if (last) begin
         phase_in     = PH_SCAN;
         key_pos_in   = '0;
         key_match_in = 1'b0;
         esc_in       = 1'b0;
         count_in     = '0;
         acc_in       = '0;
         neg_in       = 1'b0;
         digit_in     = 1'b0;
      end
   end

   // Pack the result beats in order.
   always_comb begin
      push.second = res_b;
      if (res_a_vld) begin
         push.first = res_a;
         push.count = res_b_vld ? 2'd2 : 2'd1;
      end else begin
         push.first = res_b;
         push.count = res_b_vld ? 2'd1 : 2'd0;
      end
      if (!take) begin
         push.count = 2'd0;
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SCAN;
         key_pos_ff   <= '0;
         key_match_ff <= 1'b0;
         esc_ff       <= 1'b0;
         count_ff     <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         digit_ff     <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         key_pos_ff   <= key_pos_in;
         key_match_ff <= key_match_in;
         esc_ff       <= esc_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         digit_ff     <= digit_in;
      end
   end

   // A second beat from one byte is always the end-of-document status.
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> push.second.is_final)
      else $error("second result beat is not a final status");

   // A character beat carries no status.
   assert property (@(posedge clock) disable iff (reset)
      ((push.count != 2'd0) && !push.first.is_final) |-> (push.first.status == STATUS_OK))
      else $error("character beat with nonzero status");

   // The end of a document always returns the parser to scanning.
   assert property (@(posedge clock) disable iff (reset)
      (take && last) |=> ((phase_ff == PH_SCAN) && !digit_ff && (count_ff == '0)))
      else $error("parser state not cleared at end of document");

endmodule

// File: hw/rtl/jkv_rsp_fifo.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor result queue
// Small queue: takes up to two result beats per cycle, gives one if rsp_ready.
// ----------------------------------------------------------------------------
module jkv_rsp_fifo import jkv_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   output logic            room,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int PW = $clog2(RSP_DEPTH);
   localparam int CW = $clog2(RSP_DEPTH + 1);

   rsp_payload_type mem_ff [RSP_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (cnt_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   // Room for two beats regardless of the output side.
   assign room        = (cnt_ff <= CW'(RSP_DEPTH - 2));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push.count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      cnt_in    = cnt_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage for queued beats.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   // The fill count never goes past the depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(RSP_DEPTH))
      else $error("result queue fill count beyond depth");

   // Pointers stay consistent with the fill count.
   assert property (@(posedge clock) disable iff (reset)
      PW'(wr_ptr_ff - rd_ptr_ff) == PW'(cnt_ff))
      else $error("result queue pointers disagree with fill count");

   // A push never overruns the queue.
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> ((cnt_ff + CW'(push.count)) <= CW'(RSP_DEPTH)))
      else $error("result queue overrun");

endmodule

// File: sim/json_key_value_extractor_core_test.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor testbench
// Streams JSON documents into the extractor under several key, value-kind and
// character-limit settings. A built-in parser model predicts every result
// beat, and each returned beat is compared field by field with the oldest
// prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module json_key_value_extractor_core_test;
   import jkv_pkg::*;

   localparam logic [2:0] CSR_UNUSED   = 3'd7;
   localparam logic       KIND_NUMBER  = ~KIND_STRING;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam int         QUIET_LIMIT  = 5000;
   localparam int         SHOWN_ERRORS = 10;

   // Parser position within the document.
   typedef enum logic [3:0] {
      SEEK_QUOTE,
      IN_NAME,
      WANT_COLON,
      BEFORE_VALUE,
      IN_STRING,
      IN_NUMBER,
      FINISHED
   } parse_phase_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en = 1'b0;
   logic [2:0]      csr_index = '0;
   logic [63:0]     csr_wdata = '0;

   // Register copies used by the parser model.
   logic [63:0]     cfg_key_words [0:3];
   logic [5:0]      cfg_key_len;
   logic            cfg_kind;
   logic [11:0]     cfg_max_chars;

   // Parser model state.
   parse_phase_type parse_phase;
   logic [5:0]      key_pos;
   logic            key_alive;
   logic            esc_pending;
   logic [11:0]     char_count;
   logic [31:0]     int_acc;
   logic            int_negative;
   logic            int_digit_seen;

   rsp_payload_type expected_results [$];
   req_payload_type doc_bytes [$];
   logic [7:0]      doc_text [$];
   logic [7:0]      key_text [0:31];
   int              key_chars = 0;
   int              bytes_sent = 0;
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;

   json_key_value_extractor_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------

   function automatic logic json_blank(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
   endfunction

   function automatic logic [31:0] signed_number();
      return int_negative ? 32'd0 - int_acc : int_acc;
   endfunction

   task automatic reset_doc();
      parse_phase    = SEEK_QUOTE;
      key_pos        = '0;
      key_alive      = 1'b0;
      esc_pending    = 1'b0;
      char_count     = '0;
      int_acc        = '0;
      int_negative   = 1'b0;
      int_digit_seen = 1'b0;
   endtask

   task automatic open_name();
      parse_phase = IN_NAME;
      key_pos     = '0;
      key_alive   = 1'b1;
      esc_pending = 1'b0;
   endtask

   task automatic push_final(input logic [2:0] st, input logic [31:0] iv,
                             input logic [11:0] len);
      rsp_payload_type r;
      r.is_final      = 1'b1;
      r.value_char    = '0;
      r.status        = st;
      r.int_value     = iv;
      r.string_length = len;
      expected_results.push_back(r);
   endtask

   task automatic push_char(input logic [7:0] ch);
      rsp_payload_type r;
      r               = '0;
      r.value_char    = ch;
      expected_results.push_back(r);
   endtask

   // Advance the model by one accepted byte and queue the beats it causes.
   task automatic track_byte(input req_payload_type beat);
      logic [7:0] b;
      logic [7:0] ch;
      logic [5:0] klen;
      logic       emit;
      logic       number_byte;
      b           = beat.data_byte;
      klen        = (cfg_key_len > 6'd32) ? 6'd32 : cfg_key_len;
      number_byte = 1'b0;
      ch          = b;
      emit        = 1'b0;

      // An empty key ignores everything up to the end of the document.
      if (parse_phase != FINISHED && klen == 6'd0) begin
         if (beat.end_of_document) begin
            push_final(STATUS_EMPTY_KEY, '0, '0);
            reset_doc();
         end
         return;
      end

      case (parse_phase)
         SEEK_QUOTE: begin
            if (b == CH_QUOTE) open_name();
         end
         IN_NAME: begin
            if (esc_pending) begin
               esc_pending = 1'b0;
            end else if (b == CH_BACKSLASH) begin
               esc_pending = 1'b1;
               key_alive   = 1'b0;
            end else if (b == CH_QUOTE) begin
               parse_phase = (key_alive && key_pos == klen) ? WANT_COLON : SEEK_QUOTE;
            end else if (key_alive) begin
               if (key_pos < klen &&
                   b == cfg_key_words[key_pos[4:3]][{key_pos[2:0], 3'b000} +: 8]) begin
                  key_pos = key_pos + 6'd1;
               end else begin
                  key_alive = 1'b0;
               end
            end
         end
         WANT_COLON: begin
            if (b == CH_COLON) parse_phase = BEFORE_VALUE;
            else if (b == CH_QUOTE) open_name();
            else if (!json_blank(b)) parse_phase = SEEK_QUOTE;
         end
         BEFORE_VALUE: begin
            if (!json_blank(b)) begin
               if (cfg_kind == KIND_STRING) begin
                  if (b == CH_QUOTE) begin
                     parse_phase = IN_STRING;
                     char_count  = '0;
                     esc_pending = 1'b0;
                  end else begin
                     push_final(STATUS_FORMAT, '0, '0);
                     parse_phase = FINISHED;
                  end
               end else if (b == CH_MINUS) begin
                  int_negative = 1'b1;
                  parse_phase  = IN_NUMBER;
               end else begin
                  // This byte is already the first one of the number.
                  parse_phase = IN_NUMBER;
                  number_byte = 1'b1;
               end
            end
         end
         IN_NUMBER: begin
            number_byte = 1'b1;
         end
         IN_STRING: begin
            emit = 1'b1;
            if (esc_pending) begin
               esc_pending = 1'b0;
               case (b)
                  CH_QUOTE, CH_BACKSLASH, CH_SLASH: ;
                  CH_LOWER_B: ch = CH_BS;
                  CH_LOWER_F: ch = CH_FF;
                  CH_LOWER_N: ch = CH_LF;
                  CH_LOWER_R: ch = CH_CR;
                  CH_LOWER_T: ch = CH_TAB;
                  default: begin
                     push_final(STATUS_FORMAT, '0, '0);
                     parse_phase = FINISHED;
                     emit        = 1'b0;
                  end
               endcase
            end else if (b == CH_BACKSLASH) begin
               esc_pending = 1'b1;
               emit        = 1'b0;
            end else if (b == CH_QUOTE) begin
               push_final(STATUS_OK, '0, char_count);
               parse_phase = FINISHED;
               emit        = 1'b0;
            end
            if (emit) begin
               if (char_count >= cfg_max_chars) begin
                  push_final(STATUS_BUFFER, '0, '0);
                  parse_phase = FINISHED;
               end else begin
                  push_char(ch);
                  char_count = char_count + 12'd1;
               end
            end
         end
         default: begin
            parse_phase = FINISHED;
         end
      endcase

      // Digits accumulate with 32-bit wrap; the first non-digit ends the number.
      if (number_byte) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            int_acc        = int_acc * 32'd10 + {24'd0, b - CH_ZERO};
            int_digit_seen = 1'b1;
         end else begin
            if (int_digit_seen) push_final(STATUS_OK, signed_number(), '0);
            else push_final(STATUS_FORMAT, '0, '0);
            parse_phase = FINISHED;
         end
      end

      // The last byte closes the document with a status unless one was given.
      if (beat.end_of_document) begin
         if (parse_phase == SEEK_QUOTE || parse_phase == WANT_COLON) begin
            push_final(STATUS_NOT_FOUND, '0, '0);
         end else if (parse_phase == IN_NUMBER && int_digit_seen) begin
            push_final(STATUS_OK, signed_number(), '0);
         end else if (parse_phase != FINISHED) begin
            push_final(STATUS_FORMAT, '0, '0);
         end
         reset_doc();
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver, result check and watchdog
   // ---------------------------------------------------------------------

   // Present the next byte once the current beat is taken, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (doc_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= doc_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic note_failure(input string what, input rsp_payload_type want,
                               input rsp_payload_type got);
      error_count++;
      if (error_count <= SHOWN_ERRORS) begin
         $display("%0t: %s: expected final=%0b char=%02h status=%0d int=%0d len=%0d",
                  $realtime, what, want.is_final, want.value_char, want.status,
                  want.int_value, want.string_length);
         $display("%0t: %s: actual   final=%0b char=%02h status=%0d int=%0d len=%0d",
                  $realtime, what, got.is_final, got.value_char, got.status,
                  got.int_value, got.string_length);
      end
   endtask

   // Check each returned beat, then feed the model with each accepted byte.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               note_failure("unexpected result beat", '0, rsp_payload);
            end else begin
               want = expected_results.pop_front();
               if (want.is_final !== rsp_payload.is_final ||
                   want.value_char !== rsp_payload.value_char ||
                   want.status !== rsp_payload.status ||
                   want.int_value !== rsp_payload.int_value ||
                   want.string_length !== rsp_payload.string_length) begin
                  note_failure("result mismatch", want, rsp_payload);
               end
            end
         end
         if (req_valid && req_ready) track_byte(req_payload);
      end
   end

   // End the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_KEY_LENGTH) cfg_key_len = data[5:0];
      else if (idx == CSR_VALUE_KIND) cfg_kind = data[0];
      else if (idx == CSR_MAX_VALUE_CHARS) cfg_max_chars = data[11:0];
      else if (idx != CSR_UNUSED) cfg_key_words[2'(idx - CSR_KEY_BYTES_0_7)] = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every byte is taken and every predicted beat has come back.
   task automatic wait_idle();
      while (doc_bytes.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE || b == CH_BACKSLASH) b = 8'h41 + 8'($urandom_range(25));
      return b;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] escape_letter(input int k);
      case (k)
         0: return CH_QUOTE;
         1: return CH_BACKSLASH;
         2: return CH_SLASH;
         3: return CH_LOWER_B;
         4: return CH_LOWER_F;
         5: return CH_LOWER_N;
         6: return CH_LOWER_R;
         default: return CH_LOWER_T;
      endcase
   endfunction

   function automatic logic [7:0] bad_escape();
      logic [7:0] b;
      logic       valid_letter;
      do begin
         b            = 8'($urandom_range(255));
         valid_letter = 1'b0;
         for (int k = 0; k < 8; k++) if (b == escape_letter(k)) valid_letter = 1'b1;
      end while (valid_letter);
      return b;
   endfunction

   // New random key text in all four words, then every other register.
   task automatic set_config(input logic [5:0] klen, input logic kind,
                             input logic [11:0] limit);
      logic [63:0] word;
      int          i;
      int          j;
      for (i = 0; i < 32; i++) key_text[i] = text_char();
      for (i = 0; i < 4; i++) begin
         for (j = 0; j < 8; j++) word[j*8 +: 8] = key_text[i*8 + j];
         csr_write(CSR_KEY_BYTES_0_7 + 3'(i), word);
      end
      word       = {$urandom, $urandom};
      word[5:0]  = klen;
      csr_write(CSR_KEY_LENGTH, word);
      word       = {$urandom, $urandom};
      word[0]    = kind;
      csr_write(CSR_VALUE_KIND, word);
      word       = {$urandom, $urandom};
      word[11:0] = limit;
      csr_write(CSR_MAX_VALUE_CHARS, word);
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      key_chars = (klen > 6'd32) ? 32 : int'(klen);
   endtask

   task automatic add_blank();
      repeat ($urandom_range(2)) doc_text.push_back(blank_char());
   endtask

   // Quoted name: the key itself, a near miss of it, or random text.
   task automatic add_name(input int sel);
      int i;
      int cut;
      doc_text.push_back(CH_QUOTE);
      case (sel)
         0: begin
            for (i = 0; i < key_chars; i++) doc_text.push_back(key_text[i]);
         end
         1: begin
            for (i = 0; i < key_chars - 1; i++) doc_text.push_back(key_text[i]);
         end
         2: begin
            for (i = 0; i < key_chars; i++) doc_text.push_back(key_text[i]);
            doc_text.push_back(text_char());
         end
         3: begin
            cut = (key_chars > 0) ? $urandom_range(key_chars - 1) : 0;
            for (i = 0; i < key_chars; i++) begin
               if (i == cut) doc_text.push_back(CH_BACKSLASH);
               doc_text.push_back(key_text[i]);
            end
         end
         default: begin
            repeat ($urandom_range(6)) begin
               if ($urandom_range(99) < 15) begin
                  doc_text.push_back(CH_BACKSLASH);
                  doc_text.push_back(escape_letter($urandom_range(7)));
               end else begin
                  doc_text.push_back(text_char());
               end
            end
         end
      endcase
      doc_text.push_back(CH_QUOTE);
   endtask

   task automatic add_string_value();
      int n;
      int r;
      r = $urandom_range(99);
      n = (r < 80) ? $urandom_range(6) : (r < 95) ? $urandom_range(12) : $urandom_range(55, 70);
      doc_text.push_back(CH_QUOTE);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 15) begin
            doc_text.push_back(CH_BACKSLASH);
            doc_text.push_back(escape_letter($urandom_range(7)));
         end else if (r < 17) begin
            doc_text.push_back(CH_BACKSLASH);
            doc_text.push_back(bad_escape());
         end else begin
            doc_text.push_back(text_char());
         end
      end
      doc_text.push_back(CH_QUOTE);
   endtask

   task automatic add_number_value();
      string edge_digits;
      int    r;
      if ($urandom_range(99) < 35) doc_text.push_back(CH_MINUS);
      r = $urandom_range(99);
      if (r < 10) begin
         // Both ends of the 32-bit range.
         edge_digits = "214748364";
         foreach (edge_digits[k]) doc_text.push_back(edge_digits[k]);
         doc_text.push_back(CH_ZERO + 8'($urandom_range(7, 8)));
      end else if (r >= 18) begin
         repeat ($urandom_range(1, 12)) doc_text.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
   endtask

   task automatic ship_doc();
      req_payload_type beat;
      foreach (doc_text[i]) begin
         beat.data_byte       = doc_text[i];
         beat.end_of_document = (i == doc_text.size() - 1);
         doc_bytes.push_back(beat);
      end
      bytes_sent += doc_text.size();
      doc_text.delete();
   endtask

   // A small object that usually has the key in one of its pairs, sometimes cut short or damaged.
   task automatic add_object();
      int pairs;
      int hit;
      int r;
      int keep;
      logic use_key;
      pairs   = $urandom_range(1, 3);
      hit     = $urandom_range(pairs - 1);
      use_key = ($urandom_range(99) < 80);
      doc_text.push_back(CH_LBRACE);
      for (int i = 0; i < pairs; i++) begin
         if (i > 0) doc_text.push_back(CH_COMMA);
         add_blank();
         add_name((i == hit && use_key) ? 0 : $urandom_range(1, 4));
         add_blank();
         r = $urandom_range(99);
         if (r < 88) doc_text.push_back(CH_COLON);
         else if (r < 94) doc_text.push_back(8'($urandom_range(255)));
         else doc_text.push_back(CH_QUOTE);
         add_blank();
         if ((cfg_kind == KIND_STRING) ^ ($urandom_range(99) < 12)) add_string_value();
         else add_number_value();
         add_blank();
      end
      doc_text.push_back(CH_RBRACE);
      r = $urandom_range(99);
      if (r < 12) begin
         keep = $urandom_range(1, doc_text.size());
         while (doc_text.size() > keep) doc_text.delete(doc_text.size() - 1);
      end else if (r < 24) begin
         repeat ($urandom_range(1, 2)) begin
            doc_text[$urandom_range(doc_text.size() - 1)] = 8'($urandom_range(255));
         end
      end
      ship_doc();
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 10)) begin
         if ($urandom_range(99) < 25) doc_text.push_back(CH_QUOTE);
         else doc_text.push_back(8'($urandom_range(255)));
      end
      ship_doc();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int         p;
      int         start_count;
      int         budget;
      logic [5:0] kl;
      logic       kd;
      logic [11:0] lim;

      for (p = 0; p < 4; p++) cfg_key_words[p] = '0;
      cfg_key_len   = '0;
      cfg_kind      = KIND_STRING;
      cfg_max_chars = MAX_CHARS_RESET;
      reset_doc();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty key after reset, a string with an escape, then numbers.
      doc_text = '{8'hFF, 8'h00};
      ship_doc();
      wait_idle();
      set_config(6'd1, KIND_STRING, MAX_CHARS_RESET);
      doc_text = '{CH_QUOTE, key_text[0], CH_QUOTE, CH_SPACE, CH_COLON, CH_QUOTE,
                   CH_LOWER_B, CH_BACKSLASH, CH_LOWER_T, CH_QUOTE};
      ship_doc();
      wait_idle();
      set_config(6'd1, KIND_NUMBER, MAX_CHARS_RESET);
      doc_text = '{CH_QUOTE, key_text[0], CH_QUOTE, CH_COLON, CH_MINUS, CH_LOWER_B};
      ship_doc();
      doc_text = '{CH_QUOTE, key_text[0], CH_QUOTE, CH_COLON, CH_NINE};
      ship_doc();

      // Random documents under a series of register settings and idle patterns.
      for (p = 0; p < 12; p++) begin
         wait_idle();
         case (p)
            0: begin kl = 6'd1; kd = KIND_STRING; lim = 12'd0; end
            1: begin kl = 6'd32; kd = KIND_NUMBER; lim = MAX_CHARS_RESET; end
            2: begin kl = 6'd63; kd = KIND_STRING; lim = 12'd4095; end
            3: begin kl = 6'd5; kd = KIND_STRING; lim = MAX_CHARS_RESET; end
            4: begin kl = 6'd0; kd = KIND_STRING; lim = MAX_CHARS_RESET; end
            5: begin kl = 6'd3; kd = KIND_NUMBER; lim = 12'd1; end
            6: begin
               kl = 6'($urandom_range(1, 8)); kd = KIND_STRING; lim = 12'($urandom_range(1, 8));
            end
            7: begin kl = 6'($urandom_range(1, 12)); kd = KIND_NUMBER; lim = 12'd4095; end
            8: begin kl = 6'd2; kd = KIND_STRING; lim = MAX_CHARS_RESET; end
            9: begin kl = 6'd40; kd = KIND_STRING; lim = 12'd2; end
            10: begin kl = 6'($urandom_range(1, 6)); kd = KIND_NUMBER; lim = 12'd0; end
            default: begin kl = 6'($urandom_range(1, 6)); kd = KIND_STRING; lim = 12'd63; end
         endcase
         set_config(kl, kd, lim);
         case (p % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 76; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 76; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         budget      = (kl == 6'd0) ? 20 : 60;
         start_count = bytes_sent;
         while (bytes_sent - start_count < budget) begin
            if ($urandom_range(99) < 72) add_object();
            else add_noise();
         end
      end

      wait_idle();
      if (expected_results.size() != 0) error_count += expected_results.size();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
